### rtl/tmm_pkg.sv
// Shared types, codes and helpers of the tridiagonal matrix multiply unit.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package tmm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_A_ROWS   = 3'd0;
  localparam logic [2:0] CFG_A_COLS   = 3'd1;
  localparam logic [2:0] CFG_B_COLS   = 3'd2;
  localparam logic [2:0] CFG_ADD_MODE = 3'd3;
  localparam logic [2:0] CFG_ALPHA    = 3'd4;

  // Coefficient selects for the shared multiplier.
  localparam logic [1:0] SEL_UPPER = 2'd0;
  localparam logic [1:0] SEL_DIAG  = 2'd1;
  localparam logic [1:0] SEL_LOWER = 2'd2;

  localparam int ACC_W = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_RND_A,
    ST_MUL_B,
    ST_RND_B,
    ST_ACC,
    ST_EMIT
  } tmm_state_e;

  typedef struct packed {
    logic [12:0]        a_rows;
    logic [12:0]        a_cols;
    logic [6:0]         b_cols;
    logic               add_mode;
    logic signed [31:0] alpha;
  } tmm_cfg_t;

  typedef struct packed {
    logic       load;
    logic       mul_scale;
    logic       rnd_scale;
    logic       mul_term;
    logic       rnd_term;
    logic       acc;
    logic       pop;
    logic [1:0] sel;
  } tmm_cmd_t;

  typedef struct packed {
    logic col_ok;
    logic emit_any;
    logic pend_one;
  } tmm_sts_t;

  // Saturating 48-bit add.
  function automatic logic signed [ACC_W-1:0] sat_add48(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/tmm_ctrl.sv
// Sequencer of the tridiagonal matrix multiply unit: handshakes and step order.
// Depends on tmm_pkg for the state type and the command and status structs.
`default_nettype none

module tmm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire tmm_pkg::tmm_sts_t sts_i,
  output tmm_pkg::tmm_cmd_t      cmd_o
);
  import tmm_pkg::*;

  tmm_state_e state_q, state_d;
  logic [1:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= SEL_UPPER;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.col_ok) begin
          state_d = ST_MUL_A;
          k_d     = SEL_UPPER;
        end
      end
      ST_MUL_A: state_d = ST_RND_A;
      ST_RND_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_RND_B;
      ST_RND_B: begin
        if (k_q == SEL_LOWER) begin
          state_d = ST_ACC;
        end else begin
          state_d = ST_MUL_A;
          k_d     = k_q + 2'd1;
        end
      end
      ST_ACC: state_d = sts_i.emit_any ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!out_stall_i && sts_i.pend_one) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o           = '0;
    cmd_o.sel       = k_q;
    in_stall_o      = (state_q != ST_IDLE);
    out_valid_o     = (state_q == ST_EMIT);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i && sts_i.col_ok;
    cmd_o.mul_scale = (state_q == ST_MUL_A);
    cmd_o.rnd_scale = (state_q == ST_RND_A);
    cmd_o.mul_term  = (state_q == ST_MUL_B);
    cmd_o.rnd_term  = (state_q == ST_RND_B);
    cmd_o.acc       = (state_q == ST_ACC);
    cmd_o.pop       = (state_q == ST_EMIT) && !out_stall_i;
  end

`ifndef SYNTH
  a_third_term_goes_to_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RND_B && k_q == SEL_LOWER) |=> (state_q == ST_ACC))
    else $error("sequencer skipped the accumulate step");
  a_nothing_to_emit_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && !sts_i.emit_any) |=> (state_q == ST_IDLE))
    else $error("sequencer entered emit with no pending result");
`endif

endmodule

`default_nettype wire

### rtl/tmm_datapath.sv
// Datapath of the tridiagonal matrix multiply unit: operand latches, shared
// multiplier, partial-sum row memory and result slots. Depends on tmm_pkg.
`default_nettype none

module tmm_datapath #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 4096,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tmm_pkg::tmm_cfg_t            cfg_i,
  input  wire tmm_pkg::tmm_cmd_t            cmd_i,
  output tmm_pkg::tmm_sts_t                 sts_o,
  input  wire logic signed [DATA_WIDTH-1:0] b_value_i,
  input  wire logic [11:0]                  row_index_i,
  input  wire logic [5:0]                   col_index_i,
  input  wire logic signed [DATA_WIDTH-1:0] coef_upper_i,
  input  wire logic signed [DATA_WIDTH-1:0] coef_diag_i,
  input  wire logic signed [DATA_WIDTH-1:0] coef_lower_i,
  input  wire logic signed [DATA_WIDTH-1:0] c_old_row_i,
  input  wire logic signed [DATA_WIDTH-1:0] c_old_below_i,
  output logic signed [DATA_WIDTH-1:0]      c_value_o,
  output logic [11:0]                       c_row_o,
  output logic [5:0]                        c_col_o,
  output logic                              last_of_run_o
);
  import tmm_pkg::*;

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PW = 32 + DATA_WIDTH;
  localparam logic [16:0] MaxRows = 17'(MAX_ROWS);
  localparam logic signed [63:0] DwMax = 64'sd2 ** (DATA_WIDTH - 1) - 64'sd1;
  localparam logic signed [63:0] DwMin = -DwMax - 64'sd1;
  localparam logic signed [63:0] AccMax = 64'sd2 ** (ACC_W - 1) - 64'sd1;
  localparam logic signed [63:0] AccMin = -AccMax - 64'sd1;

  // Latched item.
  logic signed [DATA_WIDTH-1:0] b_q, cu_q, cd_q, cl_q, old_row_q, old_below_q;
  logic [11:0]                  r_q;
  logic [5:0]                   col_q;
  logic [AW-1:0]                addr_q;

  logic signed [DATA_WIDTH-1:0] sc_q;
  logic signed [PW-1:0]         prod_q;
  logic signed [ACC_W-1:0]      term_q [3];

  logic [2*ACC_W-1:0] mem [MAX_COLS];
  logic [2*ACC_W-1:0] rd_q;

  logic signed [DATA_WIDTH-1:0] slot_val_q [3];
  logic [11:0]                  slot_row_q [3];
  logic [2:0]                   mask_q;

  // Column check and memory address.
  logic [15:0]   col_ext;
  logic [AW-1:0] addr_in;
  assign col_ext       = 16'(col_index_i);
  assign addr_in       = col_ext[AW-1:0];
  assign sts_o.col_ok  = (7'(col_index_i) < cfg_i.b_cols) && (int'(col_index_i) < MAX_COLS);

  // Shared multiplier: alpha times a coefficient, then scaled coefficient times b.
  logic signed [31:0]           mul_a;
  logic signed [DATA_WIDTH-1:0] coef_sel, mul_b;
  logic signed [63:0]           prod_ext, rnd;

  always_comb begin
    case (cmd_i.sel)
      SEL_UPPER: coef_sel = cu_q;
      SEL_DIAG:  coef_sel = cd_q;
      default:   coef_sel = cl_q;
    endcase
  end

  assign mul_a    = cmd_i.mul_scale ? cfg_i.alpha : 32'(sc_q);
  assign mul_b    = cmd_i.mul_scale ? coef_sel : b_q;
  assign prod_ext = 64'(prod_q);
  assign rnd      = (prod_ext + 64'sd32768) >>> 16;

  // Accumulation and result bookkeeping.
  logic signed [ACC_W-1:0] pc, pn, old_row48, old_below48, above, here, below;
  logic [16:0] rows17, r17;
  logic        last, e0, e1, e2;

  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [ACC_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > DwMax) return DATA_WIDTH'(DwMax);
    if (w < DwMin) return DATA_WIDTH'(DwMin);
    return DATA_WIDTH'(w);
  endfunction

  assign pc          = rd_q[2*ACC_W-1:ACC_W];
  assign pn          = rd_q[ACC_W-1:0];
  assign old_row48   = cfg_i.add_mode ? ACC_W'(old_row_q) : '0;
  assign old_below48 = cfg_i.add_mode ? ACC_W'(old_below_q) : '0;
  assign above       = sat_add48(pc, term_q[0]);
  assign here        = sat_add48((r_q == 12'd0) ? old_row48 : pn, term_q[1]);
  assign below       = sat_add48(old_below48, term_q[2]);

  assign rows17 = (17'(cfg_i.a_rows) > MaxRows) ? MaxRows : 17'(cfg_i.a_rows);
  assign r17    = 17'(r_q);
  assign last   = (cfg_i.a_cols != 13'd0) && (13'(r_q) == cfg_i.a_cols - 13'd1);
  assign e0     = (r_q != 12'd0) && (r17 - 17'd1 < rows17);
  assign e1     = last && (r17 < rows17);
  assign e2     = last && (r17 + 17'd1 < rows17);
  assign sts_o.emit_any = e0 || e1 || e2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      b_q         <= b_value_i;
      r_q         <= row_index_i;
      col_q       <= col_index_i;
      addr_q      <= addr_in;
      cu_q        <= coef_upper_i;
      cd_q        <= coef_diag_i;
      cl_q        <= coef_lower_i;
      old_row_q   <= c_old_row_i;
      old_below_q <= c_old_below_i;
      rd_q        <= mem[addr_in];
    end
    if (cmd_i.mul_scale || cmd_i.mul_term) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.rnd_scale) begin
      sc_q <= (rnd > DwMax) ? DATA_WIDTH'(DwMax) :
              (rnd < DwMin) ? DATA_WIDTH'(DwMin) : DATA_WIDTH'(rnd);
    end
    if (cmd_i.rnd_term) begin
      term_q[cmd_i.sel] <= (rnd > AccMax) ? ACC_W'(AccMax) :
                           (rnd < AccMin) ? ACC_W'(AccMin) : ACC_W'(rnd);
    end
    if (cmd_i.acc) begin
      mem[addr_q]   <= {here, below};
      slot_val_q[0] <= sat_dw(above);
      slot_val_q[1] <= sat_dw(here);
      slot_val_q[2] <= sat_dw(below);
      slot_row_q[0] <= r_q - 12'd1;
      slot_row_q[1] <= r_q;
      slot_row_q[2] <= r_q + 12'd1;
    end
  end

  // Results leave lowest slot first.
  logic [1:0] osel;
  assign osel = mask_q[0] ? 2'd0 : (mask_q[1] ? 2'd1 : 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cmd_i.acc) begin
      mask_q <= {e2, e1, e0};
    end else if (cmd_i.pop) begin
      mask_q[osel] <= 1'b0;
    end
  end

  assign sts_o.pend_one = (mask_q == 3'b001) || (mask_q == 3'b010) || (mask_q == 3'b100);
  assign c_value_o      = slot_val_q[osel];
  assign c_row_o        = slot_row_q[osel];
  assign c_col_o        = col_q;
  assign last_of_run_o  = sts_o.pend_one;

`ifndef SYNTH
  a_pop_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (mask_q != 3'b000))
    else $error("result taken with no pending slot");
`endif

endmodule

`default_nettype wire

### rtl/tridiagonal_matrix_multiply_unit.sv
// Top level of the tridiagonal matrix multiply unit: configuration registers,
// sequencer and datapath. Depends on tmm_pkg, tmm_ctrl and tmm_datapath.
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  ---------------------------------------
//  cfg      in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//  in       in         in_valid_i / in_stall_o   b_value, row/col index, coefs, old C
//  out      out        out_valid_o / out_stall_i c_value, c_row, c_col, last_of_run
//
// An item with a valid column is worked through in order: load, three coefficients of four
// steps each on the one shared multiplier, accumulate, then each result it emits, zero
// to three. An item whose column is out of range is taken and dropped. Reset clears
// the sequencer and loads the register defaults; the partial-sum row memory is not
// cleared. A stall on the output holds the current result and the unit takes no new
// item until all results have left.
`default_nettype none

module tridiagonal_matrix_multiply_unit #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 4096,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [2:0]                   cfg_idx_i,
  input  wire logic [31:0]                  cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0] b_value_i,
  input  wire logic [11:0]                  row_index_i,
  input  wire logic [5:0]                   col_index_i,
  input  wire logic signed [DATA_WIDTH-1:0] coef_upper_i,
  input  wire logic signed [DATA_WIDTH-1:0] coef_diag_i,
  input  wire logic signed [DATA_WIDTH-1:0] coef_lower_i,
  input  wire logic signed [DATA_WIDTH-1:0] c_old_row_i,
  input  wire logic signed [DATA_WIDTH-1:0] c_old_below_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0]      c_value_o,
  output logic [11:0]                       c_row_o,
  output logic [5:0]                        c_col_o,
  output logic                              last_of_run_o
);
  import tmm_pkg::*;

  // The register file. The user must see that writes arrive only while the unit is idle,
  // which the block does not enforce, so the datapath sees settled values for a whole item.
  tmm_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_rows   <= 13'd1;
      cfg_q.a_cols   <= 13'd1;
      cfg_q.b_cols   <= 7'd1;
      cfg_q.add_mode <= 1'b0;
      cfg_q.alpha    <= 32'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_A_ROWS:   cfg_q.a_rows   <= cfg_wdata_i[12:0];
        CFG_A_COLS:   cfg_q.a_cols   <= cfg_wdata_i[12:0];
        CFG_B_COLS:   cfg_q.b_cols   <= cfg_wdata_i[6:0];
        CFG_ADD_MODE: cfg_q.add_mode <= cfg_wdata_i[0];
        CFG_ALPHA:    cfg_q.alpha    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tmm_cmd_t cmd;
  tmm_sts_t sts;

  // The sequencer owns both handshakes; the datapath only follows its commands.
  tmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tmm_datapath #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .b_value_i     (b_value_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .coef_upper_i  (coef_upper_i),
    .coef_diag_i   (coef_diag_i),
    .coef_lower_i  (coef_lower_i),
    .c_old_row_i   (c_old_row_i),
    .c_old_below_i (c_old_below_i),
    .c_value_o     (c_value_o),
    .c_row_o       (c_row_o),
    .c_col_o       (c_col_o),
    .last_of_run_o (last_of_run_o)
  );

`ifndef SYNTH
  a_last_result_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_of_run_o) |=> !out_valid_o)
    else $error("results continued after the last one of an item");
`endif

endmodule

`default_nettype wire
